FILE: design/acss_pkg.sv
// acss_pkg: shared constants and types of the adaptive channel scan scheduler
// depends on nothing
package acss_pkg;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;

  // register indexes
  localparam logic [2:0] REG_TSPD      = 3'd0;
  localparam logic [2:0] REG_MAX_AGE   = 3'd1;
  localparam logic [2:0] REG_DISC_DW   = 3'd2;
  localparam logic [2:0] REG_DISC_JIT  = 3'd3;
  localparam logic [2:0] REG_TRK_DW    = 3'd4;
  localparam logic [2:0] REG_TRK_JIT   = 3'd5;
  localparam logic [2:0] REG_MIN_DW    = 3'd6;
  localparam logic [2:0] REG_MAX_DW    = 3'd7;

  // register reset values
  localparam logic [7:0]  RST_TSPD     = 8'd3;
  localparam logic [30:0] RST_MAX_AGE  = 31'd30000;
  localparam logic [15:0] RST_DISC_DW  = 16'd200;
  localparam logic [13:0] RST_DISC_JIT = 14'd20;
  localparam logic [15:0] RST_TRK_DW   = 16'd100;
  localparam logic [13:0] RST_TRK_JIT  = 14'd10;
  localparam logic [15:0] RST_MIN_DW   = 16'd50;
  localparam logic [15:0] RST_MAX_DW   = 16'd500;

  // input commands
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_OBS  = 1'b1;

  // request to the dwell unit
  typedef struct packed {
    logic        start;
    logic [15:0] base;
    logic [13:0] jit;
    logic [15:0] min_dw;
    logic [15:0] max_dw;
    logic [31:0] seed;
  } dwell_req_t;

  // answer of the dwell unit
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] dwell;
    logic [31:0] seed;
  } dwell_rsp_t;
endpackage

FILE: design/acss_in_if.sv
// acss_in_if: input channel of the scan scheduler (valid, ready, command fields)
// depends on nothing
interface acss_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now_ms;
  logic [4:0]  visited_entry;
  logic        saw_traffic;
  modport source (output valid, cmd, now_ms, visited_entry, saw_traffic, input ready);
  modport sink   (input valid, cmd, now_ms, visited_entry, saw_traffic, output ready);
endinterface

FILE: design/acss_out_if.sv
// acss_out_if: result channel of the scan scheduler (valid, ready, choice fields)
// depends on nothing
interface acss_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  chosen_entry;
  logic [15:0] dwell_ms;
  logic        was_discovery;
  modport source (output valid, chosen_entry, dwell_ms, was_discovery, input ready);
  modport sink   (input valid, chosen_entry, dwell_ms, was_discovery, output ready);
endinterface

FILE: design/acss_dwell.sv
// acss_dwell: lcg advance, bit-serial modulo jitter and clamp of the dwell time
// depends on acss_pkg
module acss_dwell import acss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  dwell_req_t req,
  output dwell_rsp_t rsp
);
  typedef enum logic [3:0] {
    D_IDLE = 4'b0001,
    D_MUL  = 4'b0010,
    D_DIV  = 4'b0100,
    D_FIN  = 4'b1000
  } dstate_t;

  dstate_t     state_r;
  logic [4:0]  cnt_r;
  logic [31:0] seed_r;
  logic [31:0] div_r;
  logic [15:0] rem_r;
  logic [14:0] span_r;
  logic [15:0] base_r;
  logic [13:0] jit_r;
  logic [15:0] min_r;
  logic [15:0] max_r;
  logic [15:0] dwell_r;
  logic        done_r;
  logic [15:0] trial;
  logic signed [17:0] val;

  // one remainder bit per cycle
  assign trial = {rem_r[14:0], div_r[31]};
  assign val = $signed({2'b00, base_r}) + $signed({3'b000, rem_r[14:0]})
             - $signed({4'b0000, jit_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        D_IDLE: begin
          // done holds until the next request
          if (req.start) begin
            done_r  <= 1'b0;
            seed_r  <= 32'(req.seed * LCG_MUL);
            base_r  <= req.base;
            jit_r   <= req.jit;
            min_r   <= req.min_dw;
            max_r   <= req.max_dw;
            span_r  <= {req.jit, 1'b1};
            state_r <= D_MUL;
          end
        end
        D_MUL: begin
          seed_r  <= seed_r + LCG_ADD;
          div_r   <= seed_r + LCG_ADD;
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= D_DIV;
        end
        D_DIV: begin
          div_r <= {div_r[30:0], 1'b0};
          if (trial >= {1'b0, span_r}) rem_r <= trial - {1'b0, span_r};
          else rem_r <= trial;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) state_r <= D_FIN;
        end
        D_FIN: begin
          // raise to min, then lower to max
          if (val > $signed({2'b00, max_r}) || {2'b00, min_r} > {2'b00, max_r})
            dwell_r <= max_r;
          else if (val < $signed({2'b00, min_r}))
            dwell_r <= min_r;
          else
            dwell_r <= val[15:0];
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.busy  = (state_r != D_IDLE);
  assign rsp.done  = done_r;
  assign rsp.dwell = dwell_r;
  assign rsp.seed  = seed_r;
endmodule

FILE: design/adaptive_channel_scan_scheduler.sv
// adaptive_channel_scan_scheduler: top level with entry memory, scan sequencer and apb
// depends on acss_pkg, acss_in_if, acss_out_if, acss_dwell
//
// An observation transfer reads the memory, then writes the entry back; an
// out-of-range entry is dropped without a write. A step transfer streams
// every entry through the one-read memory port and the two-stage compare,
// then passes the decision state and the dwell unit's multiply, bit-serial
// modulo, clamp and hand-over; a result register still held by a stalled
// receiver adds its wait. One item is worked on at a time; a finished
// result waits in the output register while the next item is taken. Time
// and count state live in one memory with a registered read; the visit and
// traffic valid bits are flops cleared by reset.
module adaptive_channel_scan_scheduler import acss_pkg::*; #(
  parameter int ENTRY_COUNT = 32,
  parameter logic [31:0] SEED = 32'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  acss_in_if.sink     in_ch,
  acss_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int CW = $clog2(ENTRY_COUNT + 2);
  localparam logic [CW-1:0] LAST_PTR = CW'(ENTRY_COUNT + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRY_COUNT - 1);
  localparam logic [6:0]    N7       = 7'(ENTRY_COUNT);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_OBS   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DEC   = 5'b01000,
    S_DWELL = 5'b10000
  } state_t;

  // config registers
  logic [7:0]  tspd_r;
  logic [30:0] max_age_r;
  logic [15:0] disc_dw_r, trk_dw_r, min_dw_r, max_dw_r;
  logic [13:0] disc_jit_r, trk_jit_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tspd_r     <= RST_TSPD;
      max_age_r  <= RST_MAX_AGE;
      disc_dw_r  <= RST_DISC_DW;
      disc_jit_r <= RST_DISC_JIT;
      trk_dw_r   <= RST_TRK_DW;
      trk_jit_r  <= RST_TRK_JIT;
      min_dw_r   <= RST_MIN_DW;
      max_dw_r   <= RST_MAX_DW;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_TSPD:     tspd_r     <= cfg_pwdata[7:0];
        REG_MAX_AGE:  max_age_r  <= cfg_pwdata[30:0];
        REG_DISC_DW:  disc_dw_r  <= cfg_pwdata[15:0];
        REG_DISC_JIT: disc_jit_r <= cfg_pwdata[13:0];
        REG_TRK_DW:   trk_dw_r   <= cfg_pwdata[15:0];
        REG_TRK_JIT:  trk_jit_r  <= cfg_pwdata[13:0];
        REG_MIN_DW:   min_dw_r   <= cfg_pwdata[15:0];
        REG_MAX_DW:   max_dw_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_paddr[4:2])
      REG_TSPD:     cfg_prdata = {24'd0, tspd_r};
      REG_MAX_AGE:  cfg_prdata = {1'b0, max_age_r};
      REG_DISC_DW:  cfg_prdata = {16'd0, disc_dw_r};
      REG_DISC_JIT: cfg_prdata = {18'd0, disc_jit_r};
      REG_TRK_DW:   cfg_prdata = {16'd0, trk_dw_r};
      REG_TRK_JIT:  cfg_prdata = {18'd0, trk_jit_r};
      REG_MIN_DW:   cfg_prdata = {16'd0, min_dw_r};
      REG_MAX_DW:   cfg_prdata = {16'd0, max_dw_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // entry memory: {visit_time, traffic_time, empty_count}
  logic [79:0]   mem [ENTRY_COUNT];
  logic [79:0]   rdata_r;
  logic [IW-1:0] rd_addr;
  logic          mem_we;
  logic [IW-1:0] wr_addr;
  logic [79:0]   wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wdata;
    rdata_r <= mem[rd_addr];
  end

  logic [ENTRY_COUNT-1:0] vvalid_r, tvalid_r;

  state_t        state_r;
  logic          in_acc;
  logic [31:0]   now_r;
  logic [IW-1:0] ent_r;
  logic          traffic_r;
  logic [CW-1:0] ptr_r;
  logic [IW-1:0] cursor_r;
  logic [7:0]    steps_r;
  logic [31:0]   seed_r;
  logic          overdue_r;
  logic          disc_r;
  logic [IW-1:0] chosen_r;

  // candidate stage
  logic [IW-1:0] c_idx_r;
  logic          c_vv_r, c_tv_r;
  logic [32:0]   c_vage_r, c_tage_r;
  logic [15:0]   c_cnt_r;
  // best so far
  logic [IW-1:0] b_idx_r;
  logic          b_tv_r;
  logic [32:0]   b_vage_r, b_tage_r;
  logic [15:0]   b_cnt_r;

  logic [IW-1:0] s1_idx;
  logic          s1_vv, s1_tv;
  logic          cand_better;
  logic          cand_overdue;
  logic          disc_now;
  logic [IW-1:0] chosen_now;
  logic [15:0]   old_cnt;

  logic          out_valid_r;
  logic [4:0]    out_entry_r;
  logic [15:0]   out_dwell_r;
  logic          out_disc_r;

  dwell_req_t dw_req;
  dwell_rsp_t dw_rsp;

  acss_dwell u_dwell (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dw_req),
    .rsp   (dw_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign s1_idx = IW'(ptr_r - CW'(1));
  assign s1_vv  = vvalid_r[s1_idx];
  assign s1_tv  = tvalid_r[s1_idx];
  assign old_cnt = vvalid_r[ent_r] ? rdata_r[15:0] : 16'd0;

  // read address: observation entry at accept, scan pointer otherwise
  always_comb begin
    if (state_r == S_IDLE) rd_addr = IW'(in_ch.visited_entry);
    else rd_addr = ptr_r[IW-1:0];
  end

  // observation write back
  always_comb begin
    mem_we  = (state_r == S_OBS);
    wr_addr = ent_r;
    wdata[79:48] = now_r;
    wdata[47:16] = traffic_r ? now_r : rdata_r[47:16];
    if (traffic_r) wdata[15:0] = 16'd0;
    else if (old_cnt != 16'hFFFF) wdata[15:0] = old_cnt + 16'd1;
    else wdata[15:0] = old_cnt;
  end

  // candidate against best: older visit, unobserved, older traffic, fewer empties
  always_comb begin
    if (c_vage_r != b_vage_r) cand_better = (c_vage_r > b_vage_r);
    else if (c_tv_r != b_tv_r) cand_better = !c_tv_r;
    else if (c_tage_r != b_tage_r) cand_better = (c_tage_r > b_tage_r);
    else cand_better = (c_cnt_r < b_cnt_r);
    cand_overdue = c_vv_r && (c_vage_r[31:0] > {1'b0, max_age_r});
  end

  assign disc_now   = overdue_r || (steps_r >= tspd_r);
  assign chosen_now = disc_now ? b_idx_r : cursor_r;

  always_comb begin
    dw_req.start  = (state_r == S_DEC);
    dw_req.base   = disc_now ? disc_dw_r : trk_dw_r;
    dw_req.jit    = disc_now ? disc_jit_r : trk_jit_r;
    dw_req.min_dw = min_dw_r;
    dw_req.max_dw = max_dw_r;
    dw_req.seed   = seed_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      vvalid_r <= '0;
      tvalid_r <= '0;
      cursor_r <= '0;
      steps_r  <= RST_TSPD;
      seed_r   <= SEED;
      ptr_r    <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r     <= in_ch.now_ms;
            ent_r     <= IW'(in_ch.visited_entry);
            traffic_r <= in_ch.saw_traffic;
            ptr_r     <= '0;
            overdue_r <= 1'b0;
            if (in_ch.cmd == CMD_STEP) state_r <= S_SCAN;
            else if ({2'b00, in_ch.visited_entry} < N7) state_r <= S_OBS;
          end
        end
        S_OBS: begin
          vvalid_r[ent_r] <= 1'b1;
          if (traffic_r) tvalid_r[ent_r] <= 1'b1;
          state_r <= S_IDLE;
        end
        S_SCAN: begin
          ptr_r <= ptr_r + CW'(1);
          // stage one: ages from memory data
          if (ptr_r != '0) begin
            c_idx_r  <= s1_idx;
            c_vv_r   <= s1_vv;
            c_tv_r   <= s1_tv;
            c_vage_r <= s1_vv ? {1'b0, now_r - rdata_r[79:48]} : 33'h1_0000_0000;
            c_tage_r <= s1_tv ? {1'b0, now_r - rdata_r[47:16]} : 33'h1_0000_0000;
            c_cnt_r  <= s1_vv ? rdata_r[15:0] : 16'd0;
          end
          // stage two: compare and overdue
          if (ptr_r >= CW'(2)) begin
            if (cand_overdue) overdue_r <= 1'b1;
            if (ptr_r == CW'(2) || cand_better) begin
              b_idx_r  <= c_idx_r;
              b_tv_r   <= c_tv_r;
              b_vage_r <= c_vage_r;
              b_tage_r <= c_tage_r;
              b_cnt_r  <= c_cnt_r;
            end
          end
          if (ptr_r == LAST_PTR) state_r <= S_DEC;
        end
        S_DEC: begin
          disc_r   <= disc_now;
          chosen_r <= chosen_now;
          cursor_r <= (chosen_now == LAST_IDX) ? '0 : chosen_now + IW'(1);
          if (disc_now) steps_r <= 8'd0;
          else if (steps_r != 8'hFF) steps_r <= steps_r + 8'd1;
          state_r <= S_DWELL;
        end
        S_DWELL: begin
          if (dw_rsp.done && (!out_valid_r || out_ch.ready)) begin
            seed_r  <= dw_rsp.seed;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DWELL && dw_rsp.done && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
      out_entry_r <= 5'(chosen_r);
      out_dwell_r <= dw_rsp.dwell;
      out_disc_r  <= disc_r;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.chosen_entry  = out_entry_r;
  assign out_ch.dwell_ms      = out_dwell_r;
  assign out_ch.was_discovery = out_disc_r;

  // checks
  a_dwell_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (min_dw_r <= max_dw_r) |->
      (out_dwell_r >= min_dw_r) && (out_dwell_r <= max_dw_r))
    else $error("dwell outside clamp bounds");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r <= LAST_PTR))
    else $error("scan pointer overran the table");

  a_accept_dwell_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !dw_rsp.busy)
    else $error("transfer accepted while dwell unit busy");
endmodule

FILE: verif/acss_checker.sv
// acss_checker: scoreboard for the adaptive channel scan scheduler
// watches the input, result and apb channels; depends on acss_pkg, acss_in_if, acss_out_if
module acss_checker import acss_pkg::*; #(
  parameter int ENTRY_COUNT = 32,
  parameter logic [31:0] SEED = 32'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  acss_in_if          in_ch,
  acss_out_if         out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          pending,
  output int          errors,
  output int          step_count,
  output int          obs_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0]  chosen_entry;
    logic [15:0] dwell_ms;
    logic        was_discovery;
  } choice_t;

  choice_t expected_choices[$];

  // register copies
  logic [7:0]  tspd;
  logic [30:0] max_age;
  logic [15:0] disc_dw, trk_dw, min_dw, max_dw;
  logic [13:0] disc_jit, trk_jit;

  // entry table copy
  logic        seen_visit [ENTRY_COUNT];
  logic [31:0] visit_at   [ENTRY_COUNT];
  logic        seen_traf  [ENTRY_COUNT];
  logic [31:0] traf_at    [ENTRY_COUNT];
  logic [15:0] empties    [ENTRY_COUNT];
  int          cursor;
  logic [7:0]  since_disc;
  logic [31:0] lcg;

  function automatic logic [32:0] age_of(logic ok, logic [31:0] t, logic [31:0] now);
    return ok ? {1'b0, now - t} : 33'h1_0000_0000;
  endfunction

  // discovery preference of entry c over entry b
  function automatic logic outranks(int c, int b, logic [31:0] now);
    logic [32:0] ca, ba;
    ca = age_of(seen_visit[c], visit_at[c], now);
    ba = age_of(seen_visit[b], visit_at[b], now);
    if (ca != ba) return ca > ba;
    if (seen_traf[c] != seen_traf[b]) return !seen_traf[c];
    ca = age_of(seen_traf[c], traf_at[c], now);
    ba = age_of(seen_traf[b], traf_at[b], now);
    if (ca != ba) return ca > ba;
    if (empties[c] != empties[b]) return empties[c] < empties[b];
    return c < b;
  endfunction

  // advance the lcg and form the clamped dwell
  function automatic logic [15:0] next_dwell(logic [15:0] base, logic [13:0] jit);
    logic [31:0] span;
    int v;
    lcg  = lcg * LCG_MUL + LCG_ADD;
    span = {17'd0, jit, 1'b1};
    v = int'(base) + int'(lcg % span) - int'(jit);
    if (v < int'(min_dw)) v = int'(min_dw);
    if (v > int'(max_dw)) v = int'(max_dw);
    return v[15:0];
  endfunction

  function automatic choice_t next_choice(logic [31:0] now);
    choice_t c;
    logic overdue;
    int best;
    overdue = 1'b0;
    for (int i = 0; i < ENTRY_COUNT; i++)
      if (seen_visit[i] && (now - visit_at[i]) > {1'b0, max_age}) overdue = 1'b1;
    if (overdue || since_disc >= tspd) begin
      best = 0;
      for (int i = 1; i < ENTRY_COUNT; i++)
        if (outranks(i, best, now)) best = i;
      since_disc = 8'd0;
      c.dwell_ms = next_dwell(disc_dw, disc_jit);
      c.was_discovery = 1'b1;
    end else begin
      best = cursor % ENTRY_COUNT;
      if (since_disc != 8'hff) since_disc = since_disc + 8'd1;
      c.dwell_ms = next_dwell(trk_dw, trk_jit);
      c.was_discovery = 1'b0;
    end
    cursor = (best + 1) % ENTRY_COUNT;
    c.chosen_entry = best[4:0];
    return c;
  endfunction

  always @(posedge clk) begin
    choice_t got, want;
    if (!rst_n) begin
      tspd = RST_TSPD; max_age = RST_MAX_AGE; disc_dw = RST_DISC_DW; disc_jit = RST_DISC_JIT;
      trk_dw = RST_TRK_DW; trk_jit = RST_TRK_JIT; min_dw = RST_MIN_DW; max_dw = RST_MAX_DW;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        seen_visit[i] = 1'b0; seen_traf[i] = 1'b0; empties[i] = 16'd0;
        visit_at[i] = 32'd0; traf_at[i] = 32'd0;
      end
      cursor = 0;
      since_disc = RST_TSPD;
      lcg = SEED;
      expected_choices.delete();
      errors = 0; step_count = 0; obs_count = 0;
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_TSPD:     tspd     = cfg_pwdata[7:0];
          REG_MAX_AGE:  max_age  = cfg_pwdata[30:0];
          REG_DISC_DW:  disc_dw  = cfg_pwdata[15:0];
          REG_DISC_JIT: disc_jit = cfg_pwdata[13:0];
          REG_TRK_DW:   trk_dw   = cfg_pwdata[15:0];
          REG_TRK_JIT:  trk_jit  = cfg_pwdata[13:0];
          REG_MIN_DW:   min_dw   = cfg_pwdata[15:0];
          REG_MAX_DW:   max_dw   = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      // result transfer against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.chosen_entry, out_ch.dwell_ms, out_ch.was_discovery};
        if (expected_choices.size() == 0) begin
          $display("%t: unexpected result entry %0d dwell %0d disc %0b", $realtime,
                   got.chosen_entry, got.dwell_ms, got.was_discovery);
          errors++;
        end else begin
          want = expected_choices.pop_front();
          if (got.chosen_entry != want.chosen_entry) begin
            $display("%t: chosen_entry expected %0d actual %0d", $realtime,
                     want.chosen_entry, got.chosen_entry);
            errors++;
          end
          if (got.dwell_ms != want.dwell_ms) begin
            $display("%t: dwell_ms expected %0d actual %0d", $realtime,
                     want.dwell_ms, got.dwell_ms);
            errors++;
          end
          if (got.was_discovery != want.was_discovery) begin
            $display("%t: was_discovery expected %0b actual %0b", $realtime,
                     want.was_discovery, got.was_discovery);
            errors++;
          end
        end
      end
      // input transfer
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_STEP) begin
          expected_choices.insert(expected_choices.size(), next_choice(in_ch.now_ms));
          step_count++;
        end else begin
          obs_count++;
          if (int'(in_ch.visited_entry) < ENTRY_COUNT) begin
            seen_visit[in_ch.visited_entry] = 1'b1;
            visit_at[in_ch.visited_entry] = in_ch.now_ms;
            if (in_ch.saw_traffic) begin
              empties[in_ch.visited_entry] = 16'd0;
              seen_traf[in_ch.visited_entry] = 1'b1;
              traf_at[in_ch.visited_entry] = in_ch.now_ms;
            end else if (empties[in_ch.visited_entry] != 16'hffff) begin
              empties[in_ch.visited_entry] = empties[in_ch.visited_entry] + 16'd1;
            end
          end
        end
      end
    end
    pending <= expected_choices.size();
  end
endmodule

FILE: verif/tb.sv
// tb: stimulus and verdict for the adaptive channel scan scheduler
// depends on acss_pkg, acss_in_if, acss_out_if, acss_checker and the block itself
module tb;
  import acss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_NONE = 0, IDLE_SRC = 1, IDLE_SNK = 2, IDLE_BOTH = 3;
  localparam int DRAIN_CYCLES = 90;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          pending, errors, step_count, obs_count;
  int          idle_mode = IDLE_NONE;
  logic [31:0] clock_ms = 32'd0;

  acss_in_if  in_ch();
  acss_out_if out_ch();

  adaptive_channel_scan_scheduler i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  acss_checker i_checker (
    .clk, .rst_n, .in_ch, .out_ch,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .pending, .errors, .step_count, .obs_count
  );

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stalls per phase
  always @(posedge clk) begin
    if (idle_mode == IDLE_SNK) out_ch.ready <= ($urandom_range(0, 99) >= 80);
    else if (idle_mode == IDLE_BOTH) out_ch.ready <= ($urandom_range(0, 99) >= 28);
    else out_ch.ready <= 1'b1;
  end

  // one transfer on the input channel; called just after a rising edge
  task automatic send(logic cmd, logic [31:0] now, logic [4:0] ent, logic traffic);
    int gap, pct;
    gap = 0;
    pct = (idle_mode == IDLE_SRC) ? 80 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    while ($urandom_range(0, 99) < pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.now_ms <= now;
    in_ch.visited_entry <= ent;
    in_ch.saw_traffic <= traffic;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] t, logic [30:0] age, logic [15:0] ddw, logic [13:0] dj,
                          logic [15:0] tdw, logic [13:0] tj, logic [15:0] mn, logic [15:0] mx);
    reg_write(REG_TSPD, {24'd0, t});
    reg_write(REG_MAX_AGE, {1'b0, age});
    reg_write(REG_DISC_DW, {16'd0, ddw});
    reg_write(REG_DISC_JIT, {18'd0, dj});
    reg_write(REG_TRK_DW, {16'd0, tdw});
    reg_write(REG_TRK_JIT, {18'd0, tj});
    reg_write(REG_MIN_DW, {16'd0, mn});
    reg_write(REG_MAX_DW, {16'd0, mx});
  endtask

  // time moves mostly forward in small steps, sometimes far or anywhere
  task automatic tick_clock();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 2000);
    else if (r < 92) clock_ms = clock_ms + $urandom_range(0, 70000);
    else clock_ms = $urandom;
  endtask

  task automatic random_items(int n);
    for (int k = 0; k < n; k++) begin
      tick_clock();
      if ($urandom_range(0, 99) < 55)
        send(CMD_STEP, clock_ms, 5'($urandom), 1'($urandom));
      else
        send(CMD_OBS, clock_ms, 5'($urandom_range(0, 31)), 1'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0; in_ch.cmd = CMD_STEP; in_ch.now_ms = '0;
    in_ch.visited_entry = '0; in_ch.saw_traffic = 1'b0;
    out_ch.ready = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, time extremes, entry extremes, tie breaks
    send(CMD_STEP, 32'd0, 5'd0, 1'b0);
    send(CMD_STEP, 32'hffff_ffff, 5'd31, 1'b1);
    send(CMD_OBS, 32'd0, 5'd31, 1'b1);
    send(CMD_OBS, 32'hffff_ffff, 5'd0, 1'b0);
    send(CMD_OBS, 32'hffff_ffff, 5'd1, 1'b0);
    send(CMD_OBS, 32'hffff_ffff, 5'd1, 1'b0);
    send(CMD_STEP, 32'hffff_ffff, 5'd0, 1'b0);
    send(CMD_STEP, 32'd100, 5'd0, 1'b0);
    send(CMD_STEP, 32'd200, 5'd0, 1'b0);
    send(CMD_STEP, 32'd300, 5'd0, 1'b0);
    send(CMD_STEP, 32'd40000, 5'd0, 1'b0);
    for (int e = 0; e < 32; e += 3) send(CMD_OBS, 32'd50000, 5'(e), 1'(e & 1));
    send(CMD_STEP, 32'd50000, 5'd0, 1'b0);
    go_idle();

    // repeated empty visits on one entry, then ties against it
    for (int k = 0; k < 40; k++) send(CMD_OBS, 32'd7, 5'd9, 1'b0);
    send(CMD_OBS, 32'd7, 5'd10, 1'b0);
    for (int e = 0; e < 32; e++) if (e != 9 && e != 10) send(CMD_OBS, 32'd7, 5'(e), 1'b1);
    send(CMD_STEP, 32'd7, 5'd0, 1'b0);
    go_idle();

    // random phases over idling modes and register settings
    for (int p = 0; p < 8; p++) begin
      idle_mode = p % 4;
      case (p)
        0: set_regs(RST_TSPD, RST_MAX_AGE, RST_DISC_DW, RST_DISC_JIT,
                    RST_TRK_DW, RST_TRK_JIT, RST_MIN_DW, RST_MAX_DW);
        1: set_regs(8'd0, 31'd0, 16'd0, 14'd0, 16'hffff, 14'd0, 16'd0, 16'hffff);
        2: set_regs(8'd255, 31'h7fff_ffff, 16'hffff, 14'h3fff, 16'd0, 14'h3fff,
                    16'hffff, 16'd0);
        3: set_regs(8'd5, 31'd100000, 16'd1000, 14'd900, 16'd300, 14'd400, 16'd100, 16'd2000);
        4: set_regs(8'd1, 31'd2500, 16'd20, 14'd16383, 16'd65000, 14'd1000, 16'd0, 16'd65535);
        5: set_regs(8'd255, 31'd5000, 16'd500, 14'd0, 16'd500, 14'd0, 16'd600, 16'd400);
        default: set_regs(8'($urandom), 31'($urandom_range(0, 200000)), 16'($urandom),
                          14'($urandom), 16'($urandom), 14'($urandom),
                          16'($urandom_range(0, 30000)), 16'($urandom_range(30000, 65535)));
      endcase
      random_items(220);
      go_idle();
    end

    $display("covered %0d step and %0d observation transfers over 8 register settings",
             step_count, obs_count);
    $display("all four idling modes, repeated empty visits and inverted clamp bounds included");
    if (errors == 0) $display("PASS adaptive_channel_scan_scheduler");
    else $display("FAIL adaptive_channel_scan_scheduler");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("FAIL adaptive_channel_scan_scheduler");
    $finish;
  end
endmodule

FILE: filelist.f
design/acss_pkg.sv
design/acss_in_if.sv
design/acss_out_if.sv
design/acss_dwell.sv
design/adaptive_channel_scan_scheduler.sv
verif/acss_checker.sv
verif/tb.sv
